// ----- hdl/oc_pkg.sv -----
// Shared types and constants of the orbit camera datapath.
package oc_pkg;

    // Input transfer payload.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tgt_x;
        logic signed [31:0] tgt_y;
        logic signed [31:0] tgt_z;
        logic signed [15:0] delta_azimuth;
        logic signed [15:0] delta_elevation;
    } t_in;

    // Result transfer payload.
    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic               degenerate;
    } t_out;

    // Datapath widths.
    localparam int C_DIFF_W = 33;      // position minus target
    localparam int C_LEN_W = 36;       // unsigned lengths
    localparam int C_XY_W = 38;        // CORDIC vector components
    localparam int C_ANG_W = 36;       // Q30 angles
    localparam int C_FRAC_W = 31;      // unsigned Q30 factors up to one
    localparam int C_Q_SHIFT = 30;
    localparam int C_STEP_SHIFT = 18;  // Q4.12 to Q30
    localparam int C_SQRT_STEPS = 32;

    localparam longint C_Q30_HALF = 64'sd536870912;
    localparam longint C_INV_GAIN = 64'sd652032875;
    localparam longint C_PI = 64'sd3373259426;
    localparam longint C_HALF_PI = 64'sd1686629713;
    localparam longint C_TWO_PI = 64'sd6746518852;

    localparam logic [14:0] C_LIM_RESET = 15'd32440;

    // Truncated Q30 arctangent of 2^-i.
    localparam longint C_ATAN [32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 7, 3, 1, 0, 0
    };

    // Values that travel alongside the arithmetic units.
    typedef struct packed {
        logic signed [31:0]         tgt_x;
        logic signed [31:0]         tgt_y;
        logic signed [31:0]         tgt_z;
        logic signed [C_DIFF_W-1:0] dy;
        logic signed [15:0]         da;
        logic signed [15:0]         de;
        logic                       deg;
        logic                       zh;
        logic signed [C_ANG_W-1:0]  phi0;
        logic signed [C_ANG_W-1:0]  elev;
        logic [C_LEN_W-1:0]         dlen;
        logic signed [C_FRAC_W-1:0] s_c;
        logic [C_LEN_W-1:0]         nh;
        logic signed [C_XY_W-1:0]   ny;
    } t_side;

endpackage

// ----- hdl/oc_cordic.sv -----
// Pipelined CORDIC in vectoring or rotation mode, one stage per iteration.
module oc_cordic #(
    parameter int N = 16,
    parameter int W = 38,
    parameter int WZ = 36,
    parameter bit ROTATE = 1'b0,
    parameter int WS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  logic signed [WZ-1:0] i_z,
    input  logic [WS-1:0]        i_side,
    output logic                 o_valid,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic signed [WZ-1:0] o_z,
    output logic [WS-1:0]        o_side
);
    import oc_pkg::*;

    // Rotation mode spends two stages on whole-turn wrapping and one on the half-turn fold.
    localparam int NP = ROTATE ? 3 : 1;
    localparam int NT = NP + N;
    localparam logic signed [WZ-1:0] PI_Z = WZ'(C_PI);
    localparam logic signed [WZ-1:0] NEG_PI_Z = -WZ'(C_PI);
    localparam logic signed [WZ-1:0] HALF_PI_Z = WZ'(C_HALF_PI);
    localparam logic signed [WZ-1:0] NEG_HALF_PI_Z = -WZ'(C_HALF_PI);
    localparam logic signed [WZ-1:0] TWO_PI_Z = WZ'(C_TWO_PI);

    logic signed [W-1:0]  r_x [NT];
    logic signed [W-1:0]  r_y [NT];
    logic signed [WZ-1:0] r_z [NT];
    logic                 r_neg [NT];
    logic                 r_v [NT];
    logic [WS-1:0]        r_side [NT];

    for (genvar k = 0; k < NT; k++) begin : g_stage
        logic signed [W-1:0]  p_x, p_y, n_x, n_y;
        logic signed [WZ-1:0] p_z, n_z;
        logic                 p_neg, p_v, n_neg;
        logic [WS-1:0]        p_side;

        // Stage input comes from the ports or from the previous stage.
        if (k == 0) begin : g_head
            assign p_x = i_x;
            assign p_y = i_y;
            assign p_z = i_z;
            assign p_neg = 1'b0;
            assign p_v = i_valid;
            assign p_side = i_side;
        end else begin : g_link
            assign p_x = r_x[k-1];
            assign p_y = r_y[k-1];
            assign p_z = r_z[k-1];
            assign p_neg = r_neg[k-1];
            assign p_v = r_v[k-1];
            assign p_side = r_side[k-1];
        end

        if (k < NP - 1) begin : g_wrap
            // One whole turn toward the range of minus pi to pi.
            always_comb begin
                n_x = p_x;
                n_y = p_y;
                n_neg = p_neg;
                if (p_z > PI_Z) begin
                    n_z = p_z - TWO_PI_Z;
                end else if (p_z < NEG_PI_Z) begin
                    n_z = p_z + TWO_PI_Z;
                end else begin
                    n_z = p_z;
                end
            end
        end else if (k == NP - 1 && ROTATE) begin : g_fold
            // Angles beyond a quarter turn are folded and the result negated.
            always_comb begin
                n_x = p_x;
                n_y = p_y;
                if (p_z > HALF_PI_Z) begin
                    n_z = p_z - PI_Z;
                    n_neg = 1'b1;
                end else if (p_z < NEG_HALF_PI_Z) begin
                    n_z = p_z + PI_Z;
                    n_neg = 1'b1;
                end else begin
                    n_z = p_z;
                    n_neg = p_neg;
                end
            end
        end else if (k == NP - 1) begin : g_half
            // A vector in the left half plane is turned by a half turn first.
            always_comb begin
                n_neg = p_neg;
                if (p_x < 0) begin
                    n_x = -p_x;
                    n_y = -p_y;
                    n_z = (p_y >= 0) ? p_z + PI_Z : p_z - PI_Z;
                end else begin
                    n_x = p_x;
                    n_y = p_y;
                    n_z = p_z;
                end
            end
        end else begin : g_iter
            localparam int SH = k - NP;
            localparam logic signed [WZ-1:0] AT = WZ'(C_ATAN[SH]);
            logic signed [W-1:0] xs, ys;
            logic                ccw;

            // Micro-rotation by the arctangent of 2^-SH.
            assign xs = p_x >>> SH;
            assign ys = p_y >>> SH;
            assign ccw = ROTATE ? (p_z >= 0) : !(p_y > 0);
            always_comb begin
                n_neg = p_neg;
                if (ccw) begin
                    n_x = p_x - ys;
                    n_y = p_y + xs;
                    n_z = p_z - AT;
                end else begin
                    n_x = p_x + ys;
                    n_y = p_y - xs;
                    n_z = p_z + AT;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= n_x;
                r_y[k] <= n_y;
                r_z[k] <= n_z;
                r_neg[k] <= n_neg;
                r_side[k] <= p_side;
            end
        end
    end

    // The fold sign is applied on the way out.
    assign o_valid = r_v[NT-1];
    assign o_x = r_neg[NT-1] ? -r_x[NT-1] : r_x[NT-1];
    assign o_y = r_neg[NT-1] ? -r_y[NT-1] : r_y[NT-1];
    assign o_z = r_z[NT-1];
    assign o_side = r_side[NT-1];

endmodule

// ----- hdl/oc_mulq30.sv -----
// Two-stage unsigned multiply by a Q30 factor, rounded half up.
module oc_mulq30 #(
    parameter int WA = 36,
    parameter int WS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [WA-1:0]                 i_a,
    input  logic [oc_pkg::C_FRAC_W-1:0]   i_b,
    input  logic [WS-1:0]                 i_side,
    output logic                          o_valid,
    output logic [WA-1:0]                 o_p,
    output logic [WS-1:0]                 o_side
);
    import oc_pkg::*;

    localparam int WL = WA / 2;
    localparam int WH = WA - WL;
    localparam int WP = WA + C_FRAC_W + 1;

    logic [WL+C_FRAC_W-1:0] r_pl;
    logic [WH+C_FRAC_W-1:0] r_ph;
    logic                   r_v1, r_v2;
    logic [WS-1:0]          r_s1, r_s2;
    logic [WA-1:0]          r_p;
    logic [WP-1:0]          n_sum;

    // Partial products and their rounded sum.
    assign n_sum = (WP'(r_ph) << WL) + WP'(r_pl) + WP'(C_Q30_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl <= (WL+C_FRAC_W)'(i_a[WL-1:0]) * (WL+C_FRAC_W)'(i_b);
            r_ph <= (WH+C_FRAC_W)'(i_a[WA-1:WL]) * (WH+C_FRAC_W)'(i_b);
            r_s1 <= i_side;
            r_p <= n_sum[WA+C_Q_SHIFT-1:C_Q_SHIFT];
            r_s2 <= r_s1;
        end
    end

    assign o_valid = r_v2;
    assign o_p = r_p;
    assign o_side = r_s2;

endmodule

// ----- hdl/oc_isqrt.sv -----
// Pipelined floored integer square root, two radicand bits per stage.
module oc_isqrt #(
    parameter int WS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [60:0]                 i_v,
    input  logic [WS-1:0]               i_side,
    output logic                        o_valid,
    output logic [oc_pkg::C_FRAC_W-1:0] o_root,
    output logic [WS-1:0]               o_side
);
    import oc_pkg::*;

    logic [63:0]   r_rem [C_SQRT_STEPS];
    logic [63:0]   r_root [C_SQRT_STEPS];
    logic          r_v [C_SQRT_STEPS];
    logic [WS-1:0] r_side [C_SQRT_STEPS];

    for (genvar k = 0; k < C_SQRT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0]   p_rem, p_root, n_rem, n_root, trial;
        logic          p_v;
        logic [WS-1:0] p_side;

        if (k == 0) begin : g_head
            assign p_rem = 64'(i_v);
            assign p_root = '0;
            assign p_v = i_valid;
            assign p_side = i_side;
        end else begin : g_link
            assign p_rem = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_v = r_v[k-1];
            assign p_side = r_side[k-1];
        end

        // Trial subtraction for this result bit.
        assign trial = p_root + BIT;
        always_comb begin
            if (p_rem >= trial) begin
                n_rem = p_rem - trial;
                n_root = (p_root >> 1) + BIT;
            end else begin
                n_rem = p_rem;
                n_root = p_root >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[C_SQRT_STEPS-1];
    assign o_root = r_root[C_SQRT_STEPS-1][C_FRAC_W-1:0];
    assign o_side = r_side[C_SQRT_STEPS-1];

endmodule

// ----- hdl/orbit_camera_about_target_unit.sv -----
// Top level of the orbit camera unit: turns a camera about its target point.
//
// Input channel: i_in_valid / o_in_ready with payload i_in_data (camera
// position, target, azimuth and elevation steps). Result channel:
// o_out_valid / i_out_ready with payload o_out_data (new position and the
// degenerate flag). A transfer happens when valid and ready are both high.
// i_cfg_we writes the elevation sine limit from i_cfg_wdata at once.
//
// The pipeline is built from four CORDIC pipelines, the 32-stage square root
// and five two-stage multipliers. One item can be taken every cycle while
// the result channel is not stalled.
//
// Reset (synchronous, active low) empties the pipeline and loads the limit
// with its default of about 0.99. When the receiver stalls, the whole
// pipeline holds; o_in_ready stays high while the output register is empty
// or being drained, so nothing is lost or repeated.
module orbit_camera_about_target_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  oc_pkg::t_in   i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output oc_pkg::t_out  o_out_data,
    input  logic          i_cfg_we,
    input  logic [14:0]   i_cfg_wdata
);
    import oc_pkg::*;

    localparam int WS = $bits(t_side);

    // Saturate a wide sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] res;
        if (v > 40'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic         en;
    logic [14:0]  r_lim;
    logic         r_out_valid;
    t_out         r_out;

    // The pipeline advances whenever the output register can take a result.
    assign en = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= C_LIM_RESET;
        end else if (i_cfg_we) begin
            r_lim <= i_cfg_wdata;
        end
    end

    // Input stage: differences and special-case flags.
    logic signed [C_DIFF_W-1:0] n_dx, n_dy, n_dz, r0_dx, r0_dz;
    logic                       r0_v;
    t_side                      n0_side, r0_side;

    assign n_dx = C_DIFF_W'(i_in_data.pos_x) - C_DIFF_W'(i_in_data.tgt_x);
    assign n_dy = C_DIFF_W'(i_in_data.pos_y) - C_DIFF_W'(i_in_data.tgt_y);
    assign n_dz = C_DIFF_W'(i_in_data.pos_z) - C_DIFF_W'(i_in_data.tgt_z);

    always_comb begin
        n0_side = '0;
        n0_side.tgt_x = i_in_data.tgt_x;
        n0_side.tgt_y = i_in_data.tgt_y;
        n0_side.tgt_z = i_in_data.tgt_z;
        n0_side.dy = n_dy;
        n0_side.da = i_in_data.delta_azimuth;
        n0_side.de = i_in_data.delta_elevation;
        n0_side.zh = (n_dx == '0) && (n_dz == '0);
        n0_side.deg = (n_dx == '0) && (n_dy == '0) && (n_dz == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_dx <= n_dx;
            r0_dz <= n_dz;
            r0_side <= n0_side;
        end
    end

    // Horizontal length and azimuth.
    logic                      v1_v;
    logic signed [C_XY_W-1:0]  v1_x, v1_y;
    logic signed [C_ANG_W-1:0] v1_z;
    t_side                     v1_side, b_in_side, b_side;
    logic                      b_v;
    logic [C_LEN_W-1:0]        b_p;

    oc_cordic #(
        .N(CORDIC_STAGES), .W(C_XY_W), .WZ(C_ANG_W), .ROTATE(1'b0), .WS(WS)
    ) u_vec_h (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r0_v),
        .i_x(C_XY_W'(r0_dx)), .i_y(C_XY_W'(r0_dz)), .i_z('0), .i_side(r0_side),
        .o_valid(v1_v), .o_x(v1_x), .o_y(v1_y), .o_z(v1_z), .o_side(v1_side)
    );

    always_comb begin
        b_in_side = v1_side;
        b_in_side.phi0 = v1_z;
    end

    oc_mulq30 #(.WA(C_LEN_W), .WS(WS)) u_gain_h (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v1_v),
        .i_a(v1_x[C_LEN_W-1:0]), .i_b(C_FRAC_W'(C_INV_GAIN)), .i_side(b_in_side),
        .o_valid(b_v), .o_p(b_p), .o_side(b_side)
    );

    // Full length and elevation.
    logic                      v2_v;
    logic signed [C_XY_W-1:0]  v2_x, v2_y;
    logic signed [C_ANG_W-1:0] v2_z;
    t_side                     v2_side, d_in_side, d_side;
    logic                      d_v;
    logic [C_LEN_W-1:0]        d_p;

    oc_cordic #(
        .N(CORDIC_STAGES), .W(C_XY_W), .WZ(C_ANG_W), .ROTATE(1'b0), .WS(WS)
    ) u_vec_e (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(b_v),
        .i_x(C_XY_W'(b_p)), .i_y(C_XY_W'(b_side.dy)), .i_z('0), .i_side(b_side),
        .o_valid(v2_v), .o_x(v2_x), .o_y(v2_y), .o_z(v2_z), .o_side(v2_side)
    );

    always_comb begin
        d_in_side = v2_side;
        d_in_side.elev = v2_z;
    end

    oc_mulq30 #(.WA(C_LEN_W), .WS(WS)) u_gain_e (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v2_v),
        .i_a(v2_x[C_LEN_W-1:0]), .i_b(C_FRAC_W'(C_INV_GAIN)), .i_side(d_in_side),
        .o_valid(d_v), .o_p(d_p), .o_side(d_side)
    );

    // Sine of the new elevation.
    logic signed [C_ANG_W-1:0] e_ang;
    logic                      e1_v;
    logic signed [C_XY_W-1:0]  e1_x, e1_y;
    logic signed [C_ANG_W-1:0] e1_z;
    t_side                     e_in_side, e1_side;

    assign e_ang = d_side.elev + (C_ANG_W'(d_side.de) <<< C_STEP_SHIFT);

    always_comb begin
        e_in_side = d_side;
        e_in_side.dlen = d_p;
    end

    oc_cordic #(
        .N(CORDIC_STAGES), .W(C_XY_W), .WZ(C_ANG_W), .ROTATE(1'b1), .WS(WS)
    ) u_rot_e (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(d_v),
        .i_x(C_XY_W'(C_INV_GAIN)), .i_y('0), .i_z(e_ang), .i_side(e_in_side),
        .o_valid(e1_v), .o_x(e1_x), .o_y(e1_y), .o_z(e1_z), .o_side(e1_side)
    );

    // Clamp the sine to the configured limit.
    logic signed [C_XY_W-1:0] lim;
    logic signed [C_XY_W-1:0] s_clamped;
    logic                     rf_v;
    t_side                    nf_side, rf_side;

    assign lim = C_XY_W'({r_lim, 15'd0});

    always_comb begin
        if (e1_y > lim) begin
            s_clamped = lim;
        end else if (e1_y < -lim) begin
            s_clamped = -lim;
        end else begin
            s_clamped = e1_y;
        end
        nf_side = e1_side;
        nf_side.s_c = s_clamped[C_FRAC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf_v <= 1'b0;
        end else if (en) begin
            rf_v <= e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rf_side <= nf_side;
        end
    end

    // Radicand one minus sine squared, in Q60.
    logic signed [61:0] sq;
    logic [60:0]        rg_rad;
    logic               rg_v;
    t_side              rg_side;

    assign sq = rf_side.s_c * rf_side.s_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rg_v <= 1'b0;
        end else if (en) begin
            rg_v <= rf_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rg_rad <= (61'd1 << 60) - sq[60:0];
            rg_side <= rf_side;
        end
    end

    // Cosine by square root.
    logic                q_v;
    logic [C_FRAC_W-1:0] q_root;
    t_side               q_side;

    oc_isqrt #(.WS(WS)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(rg_v),
        .i_v(rg_rad), .i_side(rg_side),
        .o_valid(q_v), .o_root(q_root), .o_side(q_side)
    );

    // Horizontal length: length times cosine.
    logic               j_v;
    logic [C_LEN_W-1:0] j_p;
    t_side              j_side, k_in_side, k_side;
    logic [C_FRAC_W-1:0] s_mag;
    logic               k_v;
    logic [C_LEN_W-1:0] k_p;

    oc_mulq30 #(.WA(C_LEN_W), .WS(WS)) u_mul_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(q_v),
        .i_a(q_side.dlen), .i_b(q_root), .i_side(q_side),
        .o_valid(j_v), .o_p(j_p), .o_side(j_side)
    );

    // Vertical part: length times sine magnitude, sign put back after.
    assign s_mag = (j_side.s_c < 0) ? C_FRAC_W'(-j_side.s_c) : C_FRAC_W'(j_side.s_c);

    always_comb begin
        k_in_side = j_side;
        k_in_side.nh = j_p;
    end

    oc_mulq30 #(.WA(C_LEN_W), .WS(WS)) u_mul_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(j_v),
        .i_a(j_side.dlen), .i_b(s_mag), .i_side(k_in_side),
        .o_valid(k_v), .o_p(k_p), .o_side(k_side)
    );

    // Gain compensation for the azimuth rotation.
    logic signed [C_XY_W-1:0] ny_pos;
    t_side                    l_in_side, l_side;
    logic                     l_v;
    logic [C_LEN_W-1:0]       l_p;

    assign ny_pos = C_XY_W'(k_p);

    always_comb begin
        l_in_side = k_side;
        l_in_side.ny = (k_side.s_c < 0) ? -ny_pos : ny_pos;
    end

    oc_mulq30 #(.WA(C_LEN_W), .WS(WS)) u_gain_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(k_v),
        .i_a(k_side.nh), .i_b(C_FRAC_W'(C_INV_GAIN)), .i_side(l_in_side),
        .o_valid(l_v), .o_p(l_p), .o_side(l_side)
    );

    // Horizontal direction at the new azimuth.
    logic signed [C_ANG_W-1:0] m_ang;
    logic                      m_v;
    logic signed [C_XY_W-1:0]  m_x, m_z;
    logic signed [C_ANG_W-1:0] m_res;
    t_side                     m_side;

    assign m_ang = l_side.phi0 + (C_ANG_W'(l_side.da) <<< C_STEP_SHIFT);

    oc_cordic #(
        .N(CORDIC_STAGES), .W(C_XY_W), .WZ(C_ANG_W), .ROTATE(1'b1), .WS(WS)
    ) u_rot_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(l_v),
        .i_x(C_XY_W'(l_p)), .i_y('0), .i_z(m_ang), .i_side(l_side),
        .o_valid(m_v), .o_x(m_x), .o_y(m_z), .o_z(m_res), .o_side(m_side)
    );

    // Output stage: add the target back, saturate, pick special cases.
    t_out n_out;

    always_comb begin
        if (m_side.deg) begin
            n_out.new_pos_x = m_side.tgt_x;
            n_out.new_pos_y = m_side.tgt_y;
            n_out.new_pos_z = m_side.tgt_z;
            n_out.degenerate = 1'b1;
        end else if (m_side.zh) begin
            n_out.new_pos_x = sat32(40'(m_side.tgt_x) + 40'(m_side.nh));
            n_out.new_pos_y = sat32(40'(m_side.tgt_y) + 40'(m_side.ny));
            n_out.new_pos_z = m_side.tgt_z;
            n_out.degenerate = 1'b0;
        end else begin
            n_out.new_pos_x = sat32(40'(m_side.tgt_x) + 40'(m_x));
            n_out.new_pos_y = sat32(40'(m_side.tgt_y) + 40'(m_side.ny));
            n_out.new_pos_z = sat32(40'(m_side.tgt_z) + 40'(m_z));
            n_out.degenerate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule
